/* sv/ssfs_pkg.sv */
// ssfs_pkg: shared types, mode codes, segment tables and digit split constants
// for the seven-segment frame serializer; no dependencies
package ssfs_pkg;

    localparam int FRAME_BITS      = 32;
    localparam int BAR_LEDS        = 8;
    localparam int CNT_W           = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [CNT_W-1:0]      bit_cnt_t;

    localparam logic [1:0] MODE_DIGITS = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_MASK   = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    localparam logic [1:0] DP_NONE = 2'd0;
    localparam logic [1:0] DP_D1   = 2'd1;
    localparam logic [1:0] DP_D2   = 2'd2;
    localparam logic [1:0] DP_D3   = 2'd3;

    localparam frame_t POINT_D1 = 32'h8000_0000;
    localparam frame_t POINT_D2 = 32'h0000_0800;
    localparam frame_t POINT_D3 = 32'h0000_8000;

    // reciprocal constants for value / 1000, r / 100 and t / 10
    localparam int DIV1000_MUL   = 4194;
    localparam int DIV1000_SHIFT = 22;
    localparam int DIV100_MUL    = 41;
    localparam int DIV100_SHIFT  = 12;
    localparam int DIV10_MUL     = 205;
    localparam int DIV10_SHIFT   = 11;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] led_level;
        logic [1:0] decimal_point;
        logic [3:0] bar_index;
        logic [7:0] bar_mask;
    } ctl_t;

    function automatic logic [15:0] seg_outer(input logic [3:0] d);
        logic [15:0] s;
        case (d)
            4'd0:    s = 16'h7007;
            4'd1:    s = 16'h4001;
            4'd2:    s = 16'h300B;
            4'd3:    s = 16'h600B;
            4'd4:    s = 16'h400D;
            4'd5:    s = 16'h600E;
            4'd6:    s = 16'h700E;
            4'd7:    s = 16'h4003;
            4'd8:    s = 16'h700F;
            4'd9:    s = 16'h600F;
            default: s = 16'h0000;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] seg_middle(input logic [3:0] d);
        logic [15:0] s;
        case (d)
            4'd0:    s = 16'h0770;
            4'd1:    s = 16'h0410;
            4'd2:    s = 16'h03B0;
            4'd3:    s = 16'h06B0;
            4'd4:    s = 16'h04D0;
            4'd5:    s = 16'h06E0;
            4'd6:    s = 16'h07E0;
            4'd7:    s = 16'h0430;
            4'd8:    s = 16'h07F0;
            4'd9:    s = 16'h06F0;
            default: s = 16'h0000;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] bar_fill(input logic [3:0] lvl);
        logic [15:0] s;
        case (lvl)
            4'd0:    s = 16'h0000;
            4'd1:    s = 16'h0100;
            4'd2:    s = 16'h0300;
            4'd3:    s = 16'h0700;
            4'd4:    s = 16'h0F00;
            4'd5:    s = 16'h0F80;
            4'd6:    s = 16'h0FC0;
            4'd7:    s = 16'h0FE0;
            4'd8:    s = 16'h0FF0;
            default: s = 16'h0000;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] bar_one(input logic [3:0] idx);
        logic [15:0] s;
        case (idx)
            4'd1:    s = 16'h0100;
            4'd2:    s = 16'h0200;
            4'd3:    s = 16'h0400;
            4'd4:    s = 16'h0800;
            4'd5:    s = 16'h0080;
            4'd6:    s = 16'h0040;
            4'd7:    s = 16'h0020;
            4'd8:    s = 16'h0010;
            default: s = 16'h0000;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] bar_from_mask(input logic [7:0] mask);
        logic [15:0] s;
        s = 16'h0000;
        for (int k = 0; k < BAR_LEDS; k++) begin
            if (mask[k]) begin
                s = s | bar_one(4'(k + 1));
            end
        end
        return s;
    endfunction

    function automatic frame_t point_bits(input logic [1:0] dp);
        frame_t f;
        case (dp)
            DP_NONE: f = '0;
            DP_D1:   f = POINT_D1;
            DP_D2:   f = POINT_D2;
            DP_D3:   f = POINT_D3;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

/* sv/ssfs_if.sv */
// ssfs interfaces: request channel, internal frame channel, serial bit channel
// depends on ssfs_pkg
interface ssfs_req_if import ssfs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] value;
    logic [3:0]  led_level;
    logic [1:0]  decimal_point;
    logic [3:0]  bar_index;
    logic [7:0]  bar_mask;

    modport source (output valid, mode, value, led_level, decimal_point, bar_index,
                    bar_mask, input ready);
    modport sink   (input valid, mode, value, led_level, decimal_point, bar_index,
                    bar_mask, output ready);
endinterface

interface ssfs_frame_if import ssfs_pkg::*; ();
    logic   valid;
    logic   ready;
    frame_t frame;

    modport source (output valid, frame, input ready);
    modport sink   (input valid, frame, output ready);
endinterface

interface ssfs_bit_if import ssfs_pkg::*; ();
    logic valid;
    logic ready;
    logic serial_bit;
    logic last_bit;
    logic display_enable_n;

    modport source (output valid, serial_bit, last_bit, display_enable_n, input ready);
    modport sink   (input valid, serial_bit, last_bit, display_enable_n, output ready);
endinterface

/* sv/ssfs_front.sv */
// ssfs_front: accepts requests, splits value mod 1000 into digits over a short
// pipeline and assembles the 32-bit frame; depends on ssfs_pkg, ssfs_if
module ssfs_front import ssfs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    ssfs_req_if.sink     req,
    ssfs_frame_if.source frame_out
);

    logic        adv;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    ctl_t        s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [15:0] s1_value_reg;
    logic [28:0] s1_prod_reg;
    logic [9:0]  s2_rem_reg;
    logic [3:0]  s3_hund_reg;
    logic [6:0]  s3_rem_reg;
    frame_t      s4_frame_reg;

    logic [28:0] prod_next;
    logic [6:0]  q0;
    logic [16:0] q0_k;
    logic [10:0] r0;
    logic [9:0]  rem_next;
    logic [15:0] h_prod;
    logic [3:0]  hund_next;
    logic [10:0] h_k;
    logic [6:0]  t_next;
    logic [14:0] t_prod;
    logic [3:0]  tens;
    logic [7:0]  tens_k;
    logic [3:0]  ones;
    frame_t      frame_next;
    ctl_t        ctl_in;

    assign adv             = !s4_valid_reg || frame_out.ready;
    assign req.ready       = adv;
    assign frame_out.valid = s4_valid_reg;
    assign frame_out.frame = s4_frame_reg;

    always_comb
    begin
        ctl_in.mode          = req.mode;
        ctl_in.led_level     = req.led_level;
        ctl_in.decimal_point = req.decimal_point;
        ctl_in.bar_index     = req.bar_index;
        ctl_in.bar_mask      = req.bar_mask;
    end

    // stage 1: reciprocal product for value / 1000
    assign prod_next = 29'(req.value) * 29'(DIV1000_MUL);

    // stage 2: remainder mod 1000 with one correction step
    always_comb
    begin
        q0   = s1_prod_reg[DIV1000_SHIFT +: 7];
        q0_k = 17'(q0) * 17'd1000;
        r0   = 11'({1'b0, s1_value_reg} - q0_k);
        if (r0 >= 11'd1000)
        begin
            rem_next = 10'(r0 - 11'd1000);
        end
        else
        begin
            rem_next = r0[9:0];
        end
    end

    // stage 3: hundreds digit and remainder mod 100
    always_comb
    begin
        h_prod    = 16'(s2_rem_reg) * 16'(DIV100_MUL);
        hund_next = h_prod[DIV100_SHIFT +: 4];
        h_k       = 11'(hund_next) * 11'd100;
        t_next    = 7'(11'(s2_rem_reg) - h_k);
    end

    // stage 4: tens and ones, table lookup and frame assembly
    always_comb
    begin
        t_prod = 15'(s3_rem_reg) * 15'(DIV10_MUL);
        tens   = t_prod[DIV10_SHIFT +: 4];
        tens_k = 8'(tens) * 8'd10;
        ones   = 4'(8'(s3_rem_reg) - tens_k);
        case (s3_ctl_reg.mode)
            MODE_DIGITS:
            begin
                frame_next = {seg_outer(s3_hund_reg), 16'h0000}
                           | {16'h0000, seg_middle(tens)}
                           | {16'h0000, seg_outer(ones)}
                           | point_bits(s3_ctl_reg.decimal_point)
                           | {bar_fill(s3_ctl_reg.led_level), 16'h0000};
            end
            MODE_SINGLE: frame_next = {bar_one(s3_ctl_reg.bar_index), 16'h0000};
            MODE_MASK:   frame_next = {bar_from_mask(s3_ctl_reg.bar_mask), 16'h0000};
            default:     frame_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req.valid && (req.mode != MODE_IGNORE);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg   <= ctl_in;
            s1_value_reg <= req.value;
            s1_prod_reg  <= prod_next;
            s2_ctl_reg   <= s1_ctl_reg;
            s2_rem_reg   <= rem_next;
            s3_ctl_reg   <= s2_ctl_reg;
            s3_hund_reg  <= hund_next;
            s3_rem_reg   <= t_next;
            s4_frame_reg <= frame_next;
        end
    end

endmodule

/* sv/ssfs_queue.sv */
// ssfs_queue: small frame queue between frame builder and serializer
// depends on ssfs_pkg, ssfs_if
module ssfs_queue import ssfs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ssfs_frame_if.sink   q_in,
    ssfs_frame_if.source q_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    frame_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic               push, pop;

    assign q_in.ready  = (count_reg != CNT_QW'(DEPTH));
    assign q_out.valid = (count_reg != '0);
    assign q_out.frame = entry_reg[rd_ptr_reg];
    assign push        = q_in.valid && q_in.ready;
    assign pop         = q_out.valid && q_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= q_in.frame;
        end
    end

endmodule

/* sv/ssfs_serializer.sv */
// ssfs_serializer: shifts each frame out lsb first, one bit per beat, and
// tracks the output enable; depends on ssfs_pkg, ssfs_if
module ssfs_serializer import ssfs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    ssfs_frame_if.sink frame_in,
    ssfs_bit_if.source bits
);

    logic     busy_reg;
    logic     enabled_reg;
    bit_cnt_t cnt_reg;
    frame_t   shift_reg;
    logic     is_last;
    logic     bit_done;
    logic     load;

    assign is_last       = (cnt_reg == CNT_W'(FRAME_BITS - 1));
    assign bit_done      = bits.valid && bits.ready;
    assign frame_in.ready = !busy_reg || (bit_done && is_last);
    assign load          = frame_in.valid && frame_in.ready;

    assign bits.valid            = busy_reg;
    assign bits.serial_bit       = shift_reg[0];
    assign bits.last_bit         = is_last;
    assign bits.display_enable_n = !enabled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            enabled_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (bit_done && is_last)
            begin
                enabled_reg <= 1'b1;
            end
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (bit_done)
            begin
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= frame_in.frame;
        end
        else if (bit_done)
        begin
            shift_reg <= shift_reg >> 1;
        end
    end

endmodule

/* sv/seven_segment_frame_serializer_core.sv */
// seven_segment_frame_serializer_core: top level, frame builder, queue, serializer
// path: request beat through the four builder stages, the queue and the serializer shift register
// throughput: one bit beat per cycle while the receiver is ready, 32 bit beats per frame, set by the serializer
// the four-stage frame builder takes a request every cycle while the queue has room
// reset: async low, clears pipeline valids, queue and enable; enable_n high until first latch
// depends on ssfs_pkg, ssfs_if, ssfs_front, ssfs_queue, ssfs_serializer
module seven_segment_frame_serializer_core import ssfs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ssfs_req_if.sink   req,
    ssfs_bit_if.source bits
);

    ssfs_frame_if frame_built ();
    ssfs_frame_if frame_queued ();

    ssfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .frame_out (frame_built)
    );

    ssfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_in  (frame_built),
        .q_out (frame_queued)
    );

    ssfs_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_queued),
        .bits     (bits)
    );

endmodule

/* test/seven_segment_frame_serializer_core_tb.sv */
// testbench for seven_segment_frame_serializer_core: random display requests in bursts,
// bit-accurate frame prediction in a scoreboard class, random and long receiver stalls
// depends on ssfs_pkg, ssfs_if and the core rtl
`timescale 1ns / 1ps

module seven_segment_frame_serializer_core_tb;
    import ssfs_pkg::*;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int REPORT_LINES     = 40;

    localparam logic [15:0] OUTER_SEG [10] = '{
        16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
        16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
    };
    localparam logic [15:0] MIDDLE_SEG [10] = '{
        16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
        16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
    };
    localparam logic [15:0] FILL_SEG [9] = '{
        16'h0000, 16'h0100, 16'h0300, 16'h0700, 16'h0F00,
        16'h0F80, 16'h0FC0, 16'h0FE0, 16'h0FF0
    };
    localparam logic [15:0] SINGLE_SEG [9] = '{
        16'h0000, 16'h0100, 16'h0200, 16'h0400, 16'h0800,
        16'h0080, 16'h0040, 16'h0020, 16'h0010
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] value;
        logic [3:0]  led_level;
        logic [1:0]  decimal_point;
        logic [3:0]  bar_index;
        logic [7:0]  bar_mask;
    } display_req_t;

    typedef struct {
        logic serial_bit;
        logic last_bit;
        logic display_enable_n;
    } serial_beat_t;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

    class frame_scoreboard;
        serial_beat_t pending_beats [$];
        bit           latched_once;
        int           frames_noted;
        int           beats_checked;
        int           ignored_reqs;

        function void note_request(display_req_t r);
            frame_t       f;
            int           v;
            serial_beat_t b;
            if (r.mode == MODE_IGNORE) begin
                ignored_reqs++;
                return;
            end
            f = '0;
            case (r.mode)
                MODE_DIGITS: begin
                    v = int'(r.value) % 1000;
                    f[31:16] = OUTER_SEG[v / 100];
                    f[15:0]  = MIDDLE_SEG[(v / 10) % 10] | OUTER_SEG[v % 10];
                    if (r.led_level <= BAR_LEDS) begin
                        f[31:16] = f[31:16] | FILL_SEG[r.led_level];
                    end
                    case (r.decimal_point)
                        DP_D1:   f = f | POINT_D1;
                        DP_D2:   f = f | POINT_D2;
                        DP_D3:   f = f | POINT_D3;
                        default: f = f;
                    endcase
                end
                MODE_SINGLE: begin
                    if (r.bar_index >= 1 && r.bar_index <= BAR_LEDS) begin
                        f[31:16] = SINGLE_SEG[r.bar_index];
                    end
                end
                default: begin
                    for (int k = 0; k < BAR_LEDS; k++) begin
                        if (r.bar_mask[k]) begin
                            f[31:16] = f[31:16] | SINGLE_SEG[k + 1];
                        end
                    end
                end
            endcase
            for (int k = 0; k < FRAME_BITS; k++) begin
                b.serial_bit       = f[k];
                b.last_bit         = (k == FRAME_BITS - 1);
                b.display_enable_n = !latched_once;
                pending_beats.push_back(b);
            end
            latched_once = 1'b1;
            frames_noted++;
        endfunction

        function bit check_beat(serial_beat_t got, output string msg);
            serial_beat_t want;
            msg = "";
            if (pending_beats.size() == 0) begin
                msg = $sformatf("bit beat with none expected: bit=%0b last=%0b en_n=%0b",
                                got.serial_bit, got.last_bit, got.display_enable_n);
                return 1'b0;
            end
            want = pending_beats.pop_front();
            beats_checked++;
            if (got.serial_bit !== want.serial_bit || got.last_bit !== want.last_bit ||
                got.display_enable_n !== want.display_enable_n) begin
                msg = $sformatf("beat %0d: bit=%0b/%0b last=%0b/%0b en_n=%0b/%0b (got/exp)",
                                beats_checked - 1, got.serial_bit, want.serial_bit,
                                got.last_bit, want.last_bit,
                                got.display_enable_n, want.display_enable_n);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit idle();
            return pending_beats.size() == 0;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   err_count;
    int   hold_token;

    frame_scoreboard sb = new();

    ssfs_req_if req_ch ();
    ssfs_bit_if bit_ch ();

    seven_segment_frame_serializer_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .bits  (bit_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report(input string msg);
        err_count++;
        if (err_count <= REPORT_LINES) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    function automatic display_req_t mk(input logic [1:0] mode, input logic [15:0] value,
                                        input logic [3:0] lvl, input logic [1:0] dp,
                                        input logic [3:0] idx, input logic [7:0] mask);
        display_req_t r;
        r.mode          = mode;
        r.value         = value;
        r.led_level     = lvl;
        r.decimal_point = dp;
        r.bar_index     = idx;
        r.bar_mask      = mask;
        return r;
    endfunction

    function automatic display_req_t random_request(input bit allow_ignore);
        display_req_t r;
        r.value         = 16'($urandom);
        r.led_level     = 4'($urandom_range(0, 15));
        r.decimal_point = 2'($urandom_range(0, 3));
        r.bar_index     = 4'($urandom_range(0, 15));
        r.bar_mask      = 8'($urandom);
        if (allow_ignore && $urandom_range(0, 11) == 0) begin
            r.mode = MODE_IGNORE;
        end else begin
            r.mode = 2'($urandom_range(0, 2));
        end
        return r;
    endfunction

    task automatic send_request(input display_req_t r);
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= r.mode;
        req_ch.value         <= r.value;
        req_ch.led_level     <= r.led_level;
        req_ch.decimal_point <= r.decimal_point;
        req_ch.bar_index     <= r.bar_index;
        req_ch.bar_mask      <= r.bar_mask;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_frames();
        idle_sender(1);
        while (!sb.idle()) @(posedge clk);
    endtask

    // bursts of random requests, mode 3 ones are not counted
    task automatic random_phase(input int count);
        int sent;
        int burst;
        display_req_t r;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 10);
            repeat (burst) begin
                r = random_request(1'b1);
                send_request(r);
                if (r.mode != MODE_IGNORE) begin
                    sent++;
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                idle_sender($urandom_range(1, 70));
            end
        end
    endtask

    task automatic directed_phase();
        display_req_t list [$];
        list.push_back(mk(MODE_IGNORE, 16'hFFFF, 4'd15, DP_D3, 4'd15, 8'hFF));
        list.push_back(mk(MODE_DIGITS, 16'd888, 4'd8, DP_NONE, 4'd0, 8'h00));
        list.push_back(mk(MODE_DIGITS, 16'd0, 4'd0, DP_D1, 4'd15, 8'hFF));
        list.push_back(mk(MODE_DIGITS, 16'hFFFF, 4'd15, DP_D2, 4'd0, 8'h00));
        list.push_back(mk(MODE_DIGITS, 16'd999, 4'd9, DP_D3, 4'd8, 8'h55));
        list.push_back(mk(MODE_DIGITS, 16'd1000, 4'd1, DP_NONE, 4'd1, 8'hAA));
        list.push_back(mk(MODE_DIGITS, 16'd12345, 4'd4, DP_D1, 4'd9, 8'h0F));
        list.push_back(mk(MODE_DIGITS, 16'd1678, 4'd7, DP_D2, 4'd3, 8'hF0));
        list.push_back(mk(MODE_DIGITS, 16'd40912, 4'd5, DP_D3, 4'd6, 8'h81));
        list.push_back(mk(MODE_DIGITS, 16'd147, 4'd2, DP_NONE, 4'd12, 8'h3C));
        list.push_back(mk(MODE_SINGLE, 16'hFFFF, 4'd15, DP_D3, 4'd0, 8'hFF));
        list.push_back(mk(MODE_SINGLE, 16'd0, 4'd0, DP_NONE, 4'd1, 8'h00));
        list.push_back(mk(MODE_SINGLE, 16'd500, 4'd3, DP_D1, 4'd4, 8'h12));
        list.push_back(mk(MODE_SINGLE, 16'd77, 4'd9, DP_D2, 4'd5, 8'h34));
        list.push_back(mk(MODE_SINGLE, 16'd1, 4'd8, DP_D3, 4'd8, 8'h56));
        list.push_back(mk(MODE_SINGLE, 16'd2, 4'd1, DP_NONE, 4'd9, 8'h78));
        list.push_back(mk(MODE_SINGLE, 16'd3, 4'd6, DP_D1, 4'd15, 8'h9A));
        list.push_back(mk(MODE_IGNORE, 16'd0, 4'd0, DP_NONE, 4'd0, 8'h00));
        list.push_back(mk(MODE_MASK, 16'hFFFF, 4'd15, DP_D3, 4'd15, 8'h00));
        list.push_back(mk(MODE_MASK, 16'd0, 4'd0, DP_NONE, 4'd0, 8'hFF));
        list.push_back(mk(MODE_MASK, 16'd321, 4'd2, DP_D2, 4'd7, 8'h55));
        list.push_back(mk(MODE_MASK, 16'd654, 4'd11, DP_D1, 4'd2, 8'hAA));
        list.push_back(mk(MODE_MASK, 16'd987, 4'd4, DP_D3, 4'd10, 8'h01));
        list.push_back(mk(MODE_MASK, 16'd111, 4'd13, DP_NONE, 4'd14, 8'h80));
        foreach (list[i]) begin
            send_request(list[i]);
            if ($urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 40));
            end
        end
    endtask

    // receiver: owns ready and switches between four random stall styles
    initial begin
        int        hold_seen;
        int        hold_left;
        int        style_left;
        int        phase;
        rx_style_t style;
        hold_seen  = 0;
        hold_left  = 0;
        style_left = 0;
        phase      = 0;
        style      = RX_OPEN;
        bit_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            phase++;
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                bit_ch.ready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 120);
                end
                style_left--;
                case (style)
                    RX_OPEN:     bit_ch.ready <= 1'b1;
                    RX_LIGHT:    bit_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY:    bit_ch.ready <= 1'($urandom_range(0, 1));
                    default:     bit_ch.ready <= ((phase % 5) != 4);
                endcase
            end
        end
    end

    always @(posedge clk) begin : req_monitor
        display_req_t r;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            r.mode          = req_ch.mode;
            r.value         = req_ch.value;
            r.led_level     = req_ch.led_level;
            r.decimal_point = req_ch.decimal_point;
            r.bar_index     = req_ch.bar_index;
            r.bar_mask      = req_ch.bar_mask;
            sb.note_request(r);
        end
    end

    always @(posedge clk) begin : bit_monitor
        serial_beat_t got;
        string        msg;
        if (rst_n && bit_ch.valid && bit_ch.ready) begin
            got.serial_bit       = bit_ch.serial_bit;
            got.last_bit         = bit_ch.last_bit;
            got.display_enable_n = bit_ch.display_enable_n;
            if (!sb.check_beat(got, msg)) begin
                report(msg);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("seven_segment_frame_serializer_core verification failed");
        $finish;
    end

    initial begin
        int drain;
        err_count  = 0;
        hold_token = 0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_DIGITS;
        req_ch.value         <= '0;
        req_ch.led_level     <= '0;
        req_ch.decimal_point <= DP_NONE;
        req_ch.bar_index     <= '0;
        req_ch.bar_mask      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        directed_phase();
        drain_frames();

        random_phase(45);

        // receiver holds off while the sender keeps offering beats
        hold_token++;
        repeat (12) begin
            send_request(random_request(1'b0));
        end
        drain_frames();

        random_phase(45);

        idle_sender(1);
        drain = 0;
        while (!sb.idle() && drain < 20000) begin
            @(posedge clk);
            drain++;
        end
        if (!sb.idle()) begin
            report($sformatf("%0d bit beats never arrived", sb.pending_beats.size()));
        end
        repeat (60) @(posedge clk);

        $display("run covered %0d frames, %0d bit beats and %0d ignored requests",
                 sb.frames_noted, sb.beats_checked, sb.ignored_reqs);
        $display("including a %0d-cycle receiver hold-off and full drains", LONG_HOLD_CYCLES);
        if (err_count == 0) begin
            $display("seven_segment_frame_serializer_core verification clean");
        end else begin
            $display("seven_segment_frame_serializer_core verification failed");
        end
        $finish;
    end

endmodule
